FILE: hw/rtl/assert_macros.svh
// assertion helpers used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every edge outside reset
`define SDI_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("sdi assertion failed");

// condition must never be seen outside reset
`define SDI_ASSERT_NEVER(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("sdi forbidden condition seen");

`endif

FILE: hw/rtl/sdi_pkg.sv
// ----------------------------------------------------------------------------
// sdi_pkg
// shared types and constants of the strapdown acceleration integrator
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sdi_pkg;

   localparam logic signed [31:0] PI_Q28      = 32'sd843314857;
   localparam logic signed [31:0] HALF_PI_Q28 = 32'sd421657428;
   localparam logic signed [31:0] GAIN_Q30    = 32'sd652032874;
   localparam logic signed [50:0] GRAVITY_Q36 = 51'sd674138066780;
   localparam logic [15:0]        TIME_STEP_RESET = 16'd655;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ANGLE,
      ST_NAV,
      ST_HOLD
   } sdi_state_type;

   typedef struct packed {
      logic signed [15:0] sin_val;
      logic signed [15:0] cos_val;
   } sdi_sc_type;

   function automatic logic signed [31:0] sdi_atan(input logic [3:0] idx);
      logic signed [31:0] v;
      case (idx)
         4'd0:  v = 32'sd210828714;
         4'd1:  v = 32'sd124459457;
         4'd2:  v = 32'sd65760959;
         4'd3:  v = 32'sd33381290;
         4'd4:  v = 32'sd16755422;
         4'd5:  v = 32'sd8385879;
         4'd6:  v = 32'sd4193963;
         4'd7:  v = 32'sd2097109;
         4'd8:  v = 32'sd1048571;
         4'd9:  v = 32'sd524287;
         4'd10: v = 32'sd262144;
         4'd11: v = 32'sd131072;
         4'd12: v = 32'sd65536;
         4'd13: v = 32'sd32768;
         4'd14: v = 32'sd16384;
         4'd15: v = 32'sd8192;
         default: v = 32'sd0;
      endcase
      return v;
   endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/strapdown_accel_integrator_top.sv
// ----------------------------------------------------------------------------
// strapdown_accel_integrator_top
// A word carries yaw, pitch and roll and a body-frame acceleration. Three
// cordic lanes find sine and cosine of the angles together, then a merge
// sequencer on one shared 32x17 multiplier builds the zyx rotation, the
// navigation acceleration with gravity and the velocity and position
// updates. The result register frees the input side while a result waits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module strapdown_accel_integrator_top (
   input  wire          clock,
   input  wire          reset,
   // yaw_angle, pitch_angle, roll_angle, body_accel_x, body_accel_y, body_accel_z
   input  wire [95:0]   req_tdata,
   input  wire          req_tvalid,
   output logic         req_tready,
   // nav_accel_x/y/z, vel_x/y/z, pos_x/y/z
   output logic [287:0] rsp_tdata,
   output logic         rsp_tvalid,
   input  wire          rsp_tready,
   input  wire [15:0]   csr_data,
   input  wire          csr_valid,
   output logic         csr_ready
);
   import sdi_pkg::*;

   sdi_state_type      state_ff, state_in;
   logic [15:0]        time_step_ff;
   logic signed [15:0] accel_ff [3];
   logic               rsp_valid_ff;
   logic [287:0]       rsp_data_ff;

   logic               req_accept;
   logic               lane_start;
   logic               nav_start;
   logic               rsp_load;
   logic [2:0]         lane_done;
   sdi_sc_type         sc [3];
   logic               nav_done;
   logic signed [15:0] nav_accel [3];
   logic signed [31:0] vel [3];
   logic signed [47:0] pos [3];

   assign csr_ready  = 1'b1;
   assign req_accept = req_tvalid && req_tready;

   for (genvar g = 0; g < 3; g++) begin : g_lane
      sdi_cordic u_cordic (
         .clock (clock),
         .reset (reset),
         .start (lane_start),
         .angle ($signed(req_tdata[16*g +: 16])),
         .done  (lane_done[g]),
         .sc    (sc[g])
      );
   end

   sdi_nav u_nav (
      .clock     (clock),
      .reset     (reset),
      .start     (nav_start),
      .sc_yaw    (sc[0]),
      .sc_pitch  (sc[1]),
      .sc_roll   (sc[2]),
      .accel_x   (accel_ff[0]),
      .accel_y   (accel_ff[1]),
      .accel_z   (accel_ff[2]),
      .time_step (time_step_ff),
      .done      (nav_done),
      .nav_accel (nav_accel),
      .vel       (vel),
      .pos       (pos)
   );

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:  if (req_accept)   state_in = ST_ANGLE;
         ST_ANGLE: if (lane_done[0]) state_in = ST_NAV;
         ST_NAV:   if (nav_done)     state_in = ST_HOLD;
         ST_HOLD:  if (rsp_load)     state_in = ST_IDLE;
         default:                    state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_tready = (state_ff == ST_IDLE);
      lane_start = (state_ff == ST_IDLE) && req_tvalid;
      nav_start  = (state_ff == ST_ANGLE) && lane_done[0];
      rsp_load   = (state_ff == ST_HOLD) && (!rsp_valid_ff || rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         time_step_ff <= TIME_STEP_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_valid && csr_ready) begin
            time_step_ff <= csr_data;
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         accel_ff[0] <= req_tdata[63:48];
         accel_ff[1] <= req_tdata[79:64];
         accel_ff[2] <= req_tdata[95:80];
      end
      if (rsp_load) begin
         rsp_data_ff <= {pos[2], pos[1], pos[0], vel[2], vel[1], vel[0],
                         nav_accel[2], nav_accel[1], nav_accel[0]};
      end
   end

   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tvalid = rsp_valid_ff;

   `SDI_ASSERT(a_lanes_in_step, clock, reset, lane_done[0] |-> (lane_done[1] && lane_done[2]))
   `SDI_ASSERT(a_nav_done_in_nav, clock, reset, nav_done |-> (state_ff == ST_NAV))
   `SDI_ASSERT(a_accept_starts_lanes, clock, reset, req_accept |=> (state_ff == ST_ANGLE))
   `SDI_ASSERT_NEVER(a_load_over_full, clock, reset, rsp_load && rsp_valid_ff && !rsp_tready)

endmodule

`default_nettype wire

FILE: hw/rtl/sdi_cordic.sv
// ----------------------------------------------------------------------------
// sdi_cordic
// one angle lane: iterative rotation-mode cordic giving sine and cosine
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sdi_cordic (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  start,
   input  wire signed [15:0]    angle,
   output logic                 done,
   output sdi_pkg::sdi_sc_type  sc
);
   import sdi_pkg::*;

   logic               run_ff, run_in;
   logic [3:0]         cnt_ff, cnt_in;
   logic               neg_ff, neg_in;
   logic signed [31:0] x_ff, x_in;
   logic signed [31:0] y_ff, y_in;
   logic signed [31:0] z_ff, z_in;

   logic signed [31:0] z_raw;
   logic signed [31:0] x_sh, y_sh;
   logic signed [31:0] x_rnd, y_rnd;
   logic signed [15:0] x_cl, y_cl;

   assign z_raw = $signed({angle[15], angle, 15'b0});
   assign x_sh  = x_ff >>> cnt_ff;
   assign y_sh  = y_ff >>> cnt_ff;
   assign done  = run_ff && (cnt_ff == 4'd15);

   always_comb begin
      run_in = run_ff;
      cnt_in = cnt_ff;
      neg_in = neg_ff;
      x_in   = x_ff;
      y_in   = y_ff;
      z_in   = z_ff;
      if (start) begin
         run_in = 1'b1;
         cnt_in = 4'd0;
         x_in   = GAIN_Q30;
         y_in   = 32'sd0;
         if (z_raw > HALF_PI_Q28) begin
            z_in   = z_raw - PI_Q28;
            neg_in = 1'b1;
         end else if (z_raw < -HALF_PI_Q28) begin
            z_in   = z_raw + PI_Q28;
            neg_in = 1'b1;
         end else begin
            z_in   = z_raw;
            neg_in = 1'b0;
         end
      end else if (run_ff) begin
         cnt_in = cnt_ff + 4'd1;
         if (done) begin
            run_in = 1'b0;
         end
         if (!z_ff[31]) begin
            x_in = x_ff - y_sh;
            y_in = y_ff + x_sh;
            z_in = z_ff - sdi_atan(cnt_ff);
         end else begin
            x_in = x_ff + y_sh;
            y_in = y_ff - x_sh;
            z_in = z_ff + sdi_atan(cnt_ff);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
         cnt_ff <= 4'd0;
      end else begin
         run_ff <= run_in;
         cnt_ff <= cnt_in;
      end
      neg_ff <= neg_in;
      x_ff   <= x_in;
      y_ff   <= y_in;
      z_ff   <= z_in;
   end

   // round to q1.14 and clamp to +-1.0
   assign x_rnd = (x_ff + 32'sd32768) >>> 16;
   assign y_rnd = (y_ff + 32'sd32768) >>> 16;

   always_comb begin
      if (x_rnd > 32'sd16384)       x_cl = 16'sd16384;
      else if (x_rnd < -32'sd16384) x_cl = -16'sd16384;
      else                          x_cl = x_rnd[15:0];
      if (y_rnd > 32'sd16384)       y_cl = 16'sd16384;
      else if (y_rnd < -32'sd16384) y_cl = -16'sd16384;
      else                          y_cl = y_rnd[15:0];
      sc.cos_val = neg_ff ? -x_cl : x_cl;
      sc.sin_val = neg_ff ? -y_cl : y_cl;
   end

endmodule

`default_nettype wire

FILE: hw/rtl/sdi_nav.sv
// ----------------------------------------------------------------------------
// sdi_nav
// merge sequencer: rotation matrix, navigation acceleration and integration
// on one shared 32x17 multiplier
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sdi_nav (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  start,
   input  sdi_pkg::sdi_sc_type  sc_yaw,
   input  sdi_pkg::sdi_sc_type  sc_pitch,
   input  sdi_pkg::sdi_sc_type  sc_roll,
   input  wire signed [15:0]    accel_x,
   input  wire signed [15:0]    accel_y,
   input  wire signed [15:0]    accel_z,
   input  wire [15:0]           time_step,
   output logic                 done,
   output logic signed [15:0]   nav_accel [3],
   output logic signed [31:0]   vel [3],
   output logic signed [47:0]   pos [3]
);
   import sdi_pkg::*;

   localparam logic [4:0] LAST_STEP = 5'd29;

   logic               run_ff;
   logic [4:0]         step_ff;
   logic signed [48:0] prod_ff;
   logic signed [31:0] pss_ff, psc_ff;
   logic signed [31:0] r_ff [9];
   logic signed [49:0] acc_ff;
   logic signed [15:0] nav_ff [3];
   logic signed [31:0] vel_ff [3];
   logic signed [47:0] pos_ff [3];

   logic signed [31:0] op_a;
   logic signed [16:0] op_b;
   logic signed [16:0] dt_s;
   logic signed [31:0] rnd14;
   logic signed [50:0] acc_sum;
   logic signed [50:0] nav_rnd;
   logic signed [15:0] nav_sat;
   logic signed [31:0] vel_old;
   logic signed [32:0] vel_sum;
   logic signed [31:0] vel_sat;
   logic signed [47:0] pos_old;
   logic signed [48:0] pos_sum;
   logic signed [47:0] pos_sat;

   assign dt_s = $signed({1'b0, time_step});
   assign done = run_ff && (step_ff == LAST_STEP);

   // operand select for the shared multiplier
   always_comb begin
      op_a = 32'sd0;
      op_b = 17'sd0;
      case (step_ff)
         5'd0:  begin op_a = 32'(sc_pitch.sin_val); op_b = 17'(sc_roll.sin_val); end
         5'd1:  begin op_a = 32'(sc_pitch.sin_val); op_b = 17'(sc_roll.cos_val); end
         5'd2:  begin op_a = pss_ff;                op_b = 17'(sc_yaw.cos_val);  end
         5'd3:  begin op_a = psc_ff;                op_b = 17'(sc_yaw.cos_val);  end
         5'd4:  begin op_a = pss_ff;                op_b = 17'(sc_yaw.sin_val);  end
         5'd5:  begin op_a = psc_ff;                op_b = 17'(sc_yaw.sin_val);  end
         5'd6:  begin op_a = 32'(sc_yaw.sin_val);   op_b = 17'(sc_roll.cos_val); end
         5'd7:  begin op_a = 32'(sc_yaw.sin_val);   op_b = 17'(sc_roll.sin_val); end
         5'd8:  begin op_a = 32'(sc_yaw.cos_val);   op_b = 17'(sc_roll.cos_val); end
         5'd9:  begin op_a = 32'(sc_yaw.cos_val);   op_b = 17'(sc_roll.sin_val); end
         5'd10: begin op_a = 32'(sc_yaw.cos_val);   op_b = 17'(sc_pitch.cos_val); end
         5'd11: begin op_a = 32'(sc_yaw.sin_val);   op_b = 17'(sc_pitch.cos_val); end
         5'd12: begin op_a = 32'(sc_pitch.cos_val); op_b = 17'(sc_roll.sin_val); end
         5'd13: begin op_a = 32'(sc_pitch.cos_val); op_b = 17'(sc_roll.cos_val); end
         5'd14: begin op_a = r_ff[0];               op_b = 17'(accel_x);         end
         5'd15: begin op_a = r_ff[1];               op_b = 17'(accel_y);         end
         5'd16: begin op_a = r_ff[2];               op_b = 17'(accel_z);         end
         5'd17: begin op_a = r_ff[3];               op_b = 17'(accel_x);         end
         5'd18: begin op_a = r_ff[4];               op_b = 17'(accel_y);         end
         5'd19: begin op_a = r_ff[5];               op_b = 17'(accel_z);         end
         5'd20: begin op_a = r_ff[6];               op_b = 17'(accel_x);         end
         5'd21: begin op_a = r_ff[7];               op_b = 17'(accel_y);         end
         5'd22: begin op_a = r_ff[8];               op_b = 17'(accel_z);         end
         5'd23: begin op_a = 32'(nav_ff[0]);        op_b = dt_s;                 end
         5'd24: begin op_a = 32'(nav_ff[1]);        op_b = dt_s;                 end
         5'd25: begin op_a = vel_ff[0];             op_b = dt_s;                 end
         5'd26: begin op_a = 32'(nav_ff[2]);        op_b = dt_s;                 end
         5'd27: begin op_a = vel_ff[1];             op_b = dt_s;                 end
         5'd28: begin op_a = vel_ff[2];             op_b = dt_s;                 end
         default: begin op_a = 32'sd0;              op_b = 17'sd0;               end
      endcase
   end

   assign rnd14 = 32'((prod_ff + 49'sd8192) >>> 14);

   // row sum to q8.8 with gravity on the vertical axis
   assign acc_sum = 51'(acc_ff) + 51'(prod_ff)
                  + ((step_ff == 5'd23) ? GRAVITY_Q36 : 51'sd0);
   assign nav_rnd = (acc_sum + 51'sd134217728) >>> 28;

   always_comb begin
      if (nav_rnd > 51'sd32767)       nav_sat = 16'sh7fff;
      else if (nav_rnd < -51'sd32768) nav_sat = -16'sd32768;
      else                            nav_sat = nav_rnd[15:0];
   end

   always_comb begin
      case (step_ff)
         5'd24:   vel_old = vel_ff[0];
         5'd25:   vel_old = vel_ff[1];
         default: vel_old = vel_ff[2];
      endcase
      case (step_ff)
         5'd26:   pos_old = pos_ff[0];
         5'd28:   pos_old = pos_ff[1];
         default: pos_old = pos_ff[2];
      endcase
   end

   assign vel_sum = 33'(vel_old) + 33'((prod_ff + 49'sd128) >>> 8);
   assign pos_sum = 49'(pos_old) + ((prod_ff + 49'sd32768) >>> 16);

   always_comb begin
      if (vel_sum > 33'sd2147483647)       vel_sat = 32'sh7fffffff;
      else if (vel_sum < -33'sd2147483648) vel_sat = 32'sh80000000;
      else                                 vel_sat = vel_sum[31:0];
      if (pos_sum > 49'sd140737488355327)       pos_sat = 48'sh7fffffffffff;
      else if (pos_sum < -49'sd140737488355328) pos_sat = 48'sh800000000000;
      else                                      pos_sat = pos_sum[47:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         step_ff <= 5'd0;
      end else if (start) begin
         run_ff  <= 1'b1;
         step_ff <= 5'd0;
      end else if (run_ff) begin
         step_ff <= step_ff + 5'd1;
         if (done) begin
            run_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= op_a * op_b;
      if (run_ff) begin
         case (step_ff)
            5'd1:  pss_ff  <= prod_ff[31:0];
            5'd2:  psc_ff  <= prod_ff[31:0];
            5'd3:  r_ff[1] <= rnd14;
            5'd4:  r_ff[2] <= rnd14;
            5'd5:  r_ff[4] <= rnd14;
            5'd6:  r_ff[5] <= rnd14;
            5'd7:  r_ff[1] <= r_ff[1] - prod_ff[31:0];
            5'd8:  r_ff[2] <= r_ff[2] + prod_ff[31:0];
            5'd9:  r_ff[4] <= r_ff[4] + prod_ff[31:0];
            5'd10: r_ff[5] <= r_ff[5] - prod_ff[31:0];
            5'd11: r_ff[0] <= prod_ff[31:0];
            5'd12: r_ff[3] <= prod_ff[31:0];
            5'd13: r_ff[7] <= prod_ff[31:0];
            5'd14: begin
               r_ff[8] <= prod_ff[31:0];
               r_ff[6] <= -(32'(sc_pitch.sin_val) <<< 14);
            end
            5'd15: acc_ff    <= prod_ff;
            5'd16: acc_ff    <= 50'(acc_sum);
            5'd17: nav_ff[0] <= nav_sat;
            5'd18: acc_ff    <= prod_ff;
            5'd19: acc_ff    <= 50'(acc_sum);
            5'd20: nav_ff[1] <= nav_sat;
            5'd21: acc_ff    <= prod_ff;
            5'd22: acc_ff    <= 50'(acc_sum);
            5'd23: nav_ff[2] <= nav_sat;
            default: ;
         endcase
      end
   end

   // integrator state
   always_ff @(posedge clock) begin
      if (reset) begin
         vel_ff[0] <= 32'sd0;
         vel_ff[1] <= 32'sd0;
         vel_ff[2] <= 32'sd0;
         pos_ff[0] <= 48'sd0;
         pos_ff[1] <= 48'sd0;
         pos_ff[2] <= 48'sd0;
      end else if (run_ff) begin
         case (step_ff)
            5'd24: vel_ff[0] <= vel_sat;
            5'd25: vel_ff[1] <= vel_sat;
            5'd26: pos_ff[0] <= pos_sat;
            5'd27: vel_ff[2] <= vel_sat;
            5'd28: pos_ff[1] <= pos_sat;
            5'd29: pos_ff[2] <= pos_sat;
            default: ;
         endcase
      end
   end

   assign nav_accel = nav_ff;
   assign vel       = vel_ff;
   assign pos       = pos_ff;

endmodule

`default_nettype wire
